// ----- rtl/core/dmx_rdm_receive_framer_top_defines.svh -----
// ----------------------------------------------------------------------------
// DMX/RDM receive framer assertion macros
// Clocked assertion helpers shared by the framer RTL.
// ----------------------------------------------------------------------------
`ifndef DMX_RDM_RECEIVE_FRAMER_TOP_DEFINES_SVH
`define DMX_RDM_RECEIVE_FRAMER_TOP_DEFINES_SVH

`ifndef SYNTH
// Checked on every rising edge of aclk, held off while reset is asserted.
`define DMXRDM_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("dmx_rdm framer assertion failed");
// Checked on every rising edge of aclk, reset included.
`define DMXRDM_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("dmx_rdm framer assertion failed");
`else
`define DMXRDM_ASSERT(label, prop)
`define DMXRDM_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- rtl/core/dmxrdm_pkg.sv -----
// ----------------------------------------------------------------------------
// DMX/RDM receive framer package
// Phase and event codes, framing constants and shared item types.
// ----------------------------------------------------------------------------
package dmxrdm_pkg;

    localparam int DMX_CHANNELS = 3;
    localparam int RDM_BUF_SIZE = 256;
    localparam int RDM_MIN_LEN  = 4;

    localparam logic [9:0] DMX_CH_LIMIT  = 10'(DMX_CHANNELS);
    localparam logic [8:0] RDM_LEN_LIMIT = 9'(RDM_BUF_SIZE);
    localparam logic [7:0] RDM_LEN_MIN   = 8'(RDM_MIN_LEN);

    localparam logic [7:0] SC_DMX       = 8'h00;
    localparam logic [7:0] SC_RDM       = 8'hCC;
    localparam logic [7:0] SSC_RDM      = 8'h01;
    // start code plus sub-start code, seeds the checksum
    localparam logic [7:0] RDM_SUM_SEED = 8'hCD;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_BREAK,
        PH_DMX_SKIP,
        PH_DMX_CAPTURE,
        PH_RDM_SSC,
        PH_RDM_LEN,
        PH_RDM_BODY,
        PH_RDM_SUMH,
        PH_RDM_SUML
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_DMX,
        EV_DMX_LAST,
        EV_RDM_BYTE,
        EV_RDM_VALID,
        EV_RDM_REJECT
    } event_t;

    typedef struct packed {
        logic       framing_error;
        logic [7:0] rx_byte;
        logic       action;
    } in_item_t;

    typedef struct packed {
        event_t     event_res;
        logic [8:0] slot_index;
        logic [7:0] slot_value;
    } result_t;

    typedef struct packed {
        phase_t phase;
        logic   packet_pending;
    } status_t;

endpackage

// ----- rtl/core/dmxrdm_parser.sv -----
// ----------------------------------------------------------------------------
// DMX/RDM framing state machine
// Holds the framing state and forms the result of the item presented to it;
// state advances on step_en.
// ----------------------------------------------------------------------------
module dmxrdm_parser import dmxrdm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  in_item_t   item,
    input  logic [9:0] start_address,
    output result_t    res,
    output status_t    status
);

    phase_t      phase_reg, phase_next;
    logic [9:0]  skip_reg, skip_next;
    logic [15:0] sum_reg, sum_next;
    logic [9:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic        pending_reg, pending_next;

    logic [9:0]  skip_dec;
    logic [9:0]  pos_inc;
    logic        skip_done;
    logic        first_is_last;
    logic        cap_last;
    logic        ssc_ok;
    logic        len_ok;
    logic        body_end;
    logic        sumh_ok;
    logic        suml_ok;
    logic [7:0]  b;

    assign b             = item.rx_byte;
    assign skip_dec      = skip_reg - 10'd1;
    assign skip_done     = (skip_dec == 10'd0);
    assign pos_inc       = pos_reg + 10'd1;
    assign first_is_last = (10'd1 >= DMX_CH_LIMIT);
    assign cap_last      = (pos_inc >= DMX_CH_LIMIT);
    assign ssc_ok        = (b == SSC_RDM) && !pending_reg;
    assign len_ok        = (b >= RDM_LEN_MIN) && ({1'b0, b} < RDM_LEN_LIMIT);
    assign body_end      = (pos_inc == {2'b00, len_reg});
    assign sumh_ok       = (b == sum_reg[15:8]);
    assign suml_ok       = (b == sum_reg[7:0]);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (item.action) begin
            phase_next = phase_reg;
        end else if (item.framing_error) begin
            phase_next = PH_BREAK;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    phase_next = PH_IDLE;
                end
                PH_BREAK: begin
                    if (b == SC_DMX) begin
                        phase_next = PH_DMX_SKIP;
                    end else if (b == SC_RDM) begin
                        phase_next = PH_RDM_SSC;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_DMX_SKIP: begin
                    if (skip_done) begin
                        phase_next = first_is_last ? PH_IDLE : PH_DMX_CAPTURE;
                    end
                end
                PH_DMX_CAPTURE: begin
                    if (cap_last) begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_RDM_SSC: begin
                    phase_next = ssc_ok ? PH_RDM_LEN : PH_IDLE;
                end
                PH_RDM_LEN: begin
                    phase_next = len_ok ? PH_RDM_BODY : PH_IDLE;
                end
                PH_RDM_BODY: begin
                    if (body_end) begin
                        phase_next = PH_RDM_SUMH;
                    end
                end
                PH_RDM_SUMH: begin
                    phase_next = sumh_ok ? PH_RDM_SUML : PH_IDLE;
                end
                PH_RDM_SUML: begin
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // datapath state and result
    always_comb begin
        skip_next    = skip_reg;
        sum_next     = sum_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        pending_next = pending_reg;
        res          = '{event_res: EV_NONE, slot_index: 9'd0, slot_value: 8'd0};
        if (item.action) begin
            pending_next = 1'b0;
        end else if (!item.framing_error) begin
            unique case (phase_reg)
                PH_BREAK: begin
                    if (b == SC_DMX) begin
                        skip_next = start_address;
                    end
                end
                PH_DMX_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_done) begin
                        pos_next  = 10'd1;
                        res.event_res  = first_is_last ? EV_DMX_LAST : EV_DMX;
                        res.slot_value = b;
                    end
                end
                PH_DMX_CAPTURE: begin
                    pos_next       = pos_inc;
                    res.event_res  = cap_last ? EV_DMX_LAST : EV_DMX;
                    res.slot_index = pos_reg[8:0];
                    res.slot_value = b;
                end
                PH_RDM_SSC: begin
                    if (ssc_ok) begin
                        pos_next = 10'd3;
                    end else begin
                        res.event_res = EV_RDM_REJECT;
                    end
                end
                PH_RDM_LEN: begin
                    len_next = b;
                    if (len_ok) begin
                        sum_next       = {8'd0, RDM_SUM_SEED} + {8'd0, b};
                        res.event_res  = EV_RDM_BYTE;
                        res.slot_index = 9'd2;
                        res.slot_value = b;
                    end else begin
                        res.event_res = EV_RDM_REJECT;
                    end
                end
                PH_RDM_BODY: begin
                    pos_next       = pos_inc;
                    sum_next       = sum_reg + {8'd0, b};
                    res.event_res  = EV_RDM_BYTE;
                    res.slot_index = pos_reg[8:0];
                    res.slot_value = b;
                end
                PH_RDM_SUMH: begin
                    if (!sumh_ok) begin
                        res.event_res = EV_RDM_REJECT;
                    end
                end
                PH_RDM_SUML: begin
                    if (suml_ok) begin
                        pending_next  = 1'b1;
                        res.event_res = EV_RDM_VALID;
                    end else begin
                        res.event_res = EV_RDM_REJECT;
                    end
                end
                default: begin
                    res.event_res = EV_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            skip_reg    <= 10'd0;
            sum_reg     <= 16'd0;
            pos_reg     <= 10'd0;
            len_reg     <= 8'd0;
            pending_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            skip_reg    <= skip_next;
            sum_reg     <= sum_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            pending_reg <= pending_next;
        end
    end

    assign status = '{phase: phase_reg, packet_pending: pending_reg};

endmodule

// ----- rtl/core/dmx_rdm_receive_framer_top.sv -----
// One received byte (or a release request) per item. Items are taken one per
// clock while s_tready is high: an input register feeds the framing logic,
// whose result enters an output register when the item steps. While a result
// waits, the input side takes one more item and then holds s_tready low until
// the result is taken. Every item yields exactly one result item; event
// NONE marks bytes that produce nothing. A framing error on a byte is the
// break that restarts framing. DMX frames emit the slot at start_address and
// the following channels, the final one flagged; RDM messages emit length and
// body bytes at their buffer indices, then VALID (packet marked pending until
// a release item) or REJECTED. Write start_address only while the block is
// idle.
// ----------------------------------------------------------------------------
// DMX/RDM receive framer top level
// Stream handshake, configuration register and result register around the
// framing state machine.
// ----------------------------------------------------------------------------
`include "dmx_rdm_receive_framer_top_defines.svh"

module dmx_rdm_receive_framer_top import dmxrdm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,     // start_address
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] rx_byte
    input  logic [1:0]  s_tuser,       // [0] action, [1] framing_error
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [8:0] slot_index, [16:9] slot_value, zero above
    output logic [2:0]  m_tuser        // [2:0] event_res
);

    logic [9:0] start_addr_reg;
    logic       in_valid_reg, in_valid_next;
    in_item_t   in_item_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_res_reg;
    result_t    step_res;
    status_t    fsm_status;
    logic       advance;
    logic       step;
    logic       s_accept;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_addr_reg <= 10'd1;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                start_addr_reg <= cfg_wdata;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= '{framing_error: s_tuser[1], rx_byte: s_tdata, action: s_tuser[0]};
        end
        if (step) begin
            out_res_reg <= step_res;
        end
    end

    dmxrdm_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (step),
        .item          (in_item_reg),
        .start_address (start_addr_reg),
        .res           (step_res),
        .status        (fsm_status)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg.slot_value, out_res_reg.slot_index};
    assign m_tuser  = out_res_reg.event_res;

    // a held input item is never dropped without being processed
    `DMXRDM_ASSERT(a_in_held, in_valid_reg && !step |=> in_valid_reg)
    // a valid packet report always leaves the packet marked pending
    `DMXRDM_ASSERT(a_valid_sets_pending,
        step && (step_res.event_res == EV_RDM_VALID) |=> fsm_status.packet_pending)
    // events without payload carry zero index and value
    `DMXRDM_ASSERT(a_empty_payload,
        m_tvalid && (m_tuser == EV_NONE || m_tuser == EV_RDM_VALID ||
        m_tuser == EV_RDM_REJECT) |-> m_tdata == 24'd0)
    // nothing is presented on the result side while reset is held
    `DMXRDM_ASSERT_ALWAYS(a_reset_quiet, !$past(aresetn) |-> !m_tvalid)

endmodule
